### design/fte_pkg.sv
// Shared codes, constants and default parameters of the FAT12 table engine.
package fte_pkg;

  localparam int DEF_TABLE_SECTORS     = 9;
  localparam int DEF_SECTOR_BYTES      = 512;
  localparam int DEF_DATA_START_SECTOR = 33;

  localparam logic [15:0] DEV_SECTORS_RESET = 16'd2880;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_GET   = 3'd2;
  localparam logic [2:0] MODE_SET   = 3'd3;
  localparam logic [2:0] MODE_ALLOC = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ERR    = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  localparam logic [11:0] ENT_END_MIN = 12'hFF8;
  localparam logic [11:0] ENT_RES_MIN = 12'hFF0;
  localparam logic [11:0] ENT_END     = 12'hFFF;
  localparam logic [11:0] ENT_RES     = 12'hFF0;
  localparam logic [7:0]  NIB_LO      = 8'h0F;
  localparam logic [7:0]  NIB_HI      = 8'hF0;

  localparam logic [2:0] REG_DEV_SECTORS = 3'd0;

endpackage

### design/fte_ram.sv
// Generic one-write, one-read RAM with registered read data.
module fte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4608
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fat12_table_engine.sv
// Top level of the FAT12 table engine: sequencer, entry unit, config port and table RAM.
//
// The allocation table lives in a one-port byte RAM of TABLE_SECTORS*SECTOR_BYTES bytes
// with registered read data, and every operation is sequenced through that port, one item
// at a time; in_ready is high only while the sequencer is idle. Load byte, clear dirty and
// items rejected at accept go straight to the final step; read byte passes through a read
// step, an out-of-range get or set ends after its range check, get entry runs range check,
// two byte reads and decode, and set entry runs range check, two reads, decode and two
// writes; the sequencer then returns to idle before the next transfer. Allocation runs the
// same check, two reads and decode over each entry it visits, plus a wrap step, so it takes
// time in proportion to the distance to the first free entry (up to several thousand
// entries). One finished result waits in the output register; while it is not taken, the
// next item runs up to its final step and holds there.
// No clearing pass runs after reset: the table must be loaded before entries are read.
// Register 0 (device_sectors) sits at byte address 0 of the cfg port; the user must write
// it only while idle, and the block itself does not enforce this.
module fat12_table_engine
  import fte_pkg::*;
#(
  parameter int TABLE_SECTORS     = DEF_TABLE_SECTORS,
  parameter int SECTOR_BYTES      = DEF_SECTOR_BYTES,
  parameter int DATA_START_SECTOR = DEF_DATA_START_SECTOR
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_entry_index,
  input  logic [11:0] in_entry_value,
  input  logic [12:0] in_byte_addr,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_entry_out,
  output logic [7:0]  out_byte_out,
  output logic [1:0]  out_status,
  output logic [8:0]  out_dirty_sectors,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int STORE_BYTES = TABLE_SECTORS * SECTOR_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_EV   = 4'd4;
  localparam logic [3:0] S_WR0  = 4'd5;
  localparam logic [3:0] S_WR1  = 4'd6;
  localparam logic [3:0] S_RB   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic [2:0]               mode_r, mode_nxt;
  logic [11:0]              n_r, n_nxt;
  logic [11:0]              v_r, v_nxt;
  logic [12:0]              cur_r, cur_nxt;
  logic                     wrap_r, wrap_nxt;
  logic [7:0]               b0_r, b0_nxt;
  logic [7:0]               nb0_r, nb0_nxt;
  logic [7:0]               nb1_r, nb1_nxt;
  logic [11:0]              res_eout_r, res_eout_nxt;
  logic [7:0]               res_bout_r, res_bout_nxt;
  logic [1:0]               res_st_r, res_st_nxt;
  logic [TABLE_SECTORS-1:0] dirty_r, dirty_nxt;
  logic [15:0]              dev_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [11:0]              out_eout_r, out_eout_nxt;
  logic [7:0]               out_bout_r, out_bout_nxt;
  logic [1:0]               out_st_r, out_st_nxt;
  logic [8:0]               out_dirty_r, out_dirty_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic        in_xfer;
  logic        byte_ok;
  logic [13:0] base;
  logic        ent_ok;
  logic [11:0] raw;
  logic [11:0] cls;
  logic [AW-1:0] base_a;
  logic [AW-1:0] base1_a;

  // One-hot sector of a table byte address; compares against fixed sector limits.
  function automatic logic [TABLE_SECTORS-1:0] sector_bit(input logic [AW-1:0] a);
    logic [TABLE_SECTORS-1:0] m;
    m = '0;
    for (int k = 0; k < TABLE_SECTORS; k++) begin
      m[k] = (32'(a) >= 32'(k * SECTOR_BYTES)) && (32'(a) < 32'((k + 1) * SECTOR_BYTES));
    end
    return m;
  endfunction

  fte_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_DEV_SECTORS) ? {16'd0, dev_r} : 32'd0;

  assign out_valid         = out_valid_r;
  assign out_entry_out     = out_eout_r;
  assign out_byte_out      = out_bout_r;
  assign out_status        = out_st_r;
  assign out_dirty_sectors = out_dirty_r;

  // Shared entry unit: byte offset, range check and 12-bit unpack of the current entry.
  assign byte_ok = 32'(in_byte_addr) < 32'(STORE_BYTES);
  assign base    = 14'(cur_r) + 14'(cur_r[12:1]);
  assign ent_ok  = !cur_r[12]
                && (17'(cur_r) + 17'(DATA_START_SECTOR - 2) < 17'(dev_r))
                && (32'(base) + 32'd1 < 32'(STORE_BYTES));
  assign base_a  = AW'(base);
  assign base1_a = AW'(base + 14'd1);
  assign raw     = cur_r[0] ? {ram_rdata, b0_r[7:4]} : {ram_rdata[3:0], b0_r};

  always_comb begin
    if (raw >= ENT_END_MIN) begin
      cls = ENT_END;
    end else if (raw >= ENT_RES_MIN) begin
      cls = ENT_RES;
    end else begin
      cls = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= DEV_SECTORS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      dev_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    v_nxt         = v_r;
    cur_nxt       = cur_r;
    wrap_nxt      = wrap_r;
    b0_nxt        = b0_r;
    nb0_nxt       = nb0_r;
    nb1_nxt       = nb1_r;
    res_eout_nxt  = res_eout_r;
    res_bout_nxt  = res_bout_r;
    res_st_nxt    = res_st_r;
    dirty_nxt     = dirty_r;
    out_eout_nxt  = out_eout_r;
    out_bout_nxt  = out_bout_r;
    out_st_nxt    = out_st_r;
    out_dirty_nxt = out_dirty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_addr      = AW'(in_byte_addr);
    ram_wdata     = in_byte_in;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt     = in_mode;
          n_nxt        = in_entry_index;
          v_nxt        = in_entry_value;
          wrap_nxt     = 1'b0;
          res_eout_nxt = 12'd0;
          res_bout_nxt = 8'd0;
          res_st_nxt   = ST_OK;
          state_nxt    = S_FIN;
          unique case (in_mode)
            MODE_LOAD: begin
              if (byte_ok) begin
                ram_we = 1'b1;
              end else begin
                res_st_nxt = ST_ERR;
              end
            end
            MODE_READ: begin
              if (byte_ok) begin
                state_nxt = S_RB;
              end else begin
                res_st_nxt = ST_ERR;
              end
            end
            MODE_GET, MODE_SET: begin
              cur_nxt   = {1'b0, in_entry_index};
              state_nxt = S_CHK;
            end
            MODE_ALLOC: begin
              cur_nxt   = 13'(in_entry_index) + 13'd1;
              state_nxt = S_CHK;
            end
            MODE_CLEAR: begin
              dirty_nxt = '0;
            end
            default: begin
              res_st_nxt = ST_ERR;
            end
          endcase
        end
      end
      S_RB: begin
        res_bout_nxt = ram_rdata;
        state_nxt    = S_FIN;
      end
      S_CHK: begin
        if (mode_r == MODE_ALLOC) begin
          if (cur_r == {1'b0, n_r}) begin
            res_st_nxt = ST_NOFREE;
            state_nxt  = S_FIN;
          end else if (!ent_ok) begin
            if (wrap_r) begin
              res_st_nxt = ST_ERR;
              state_nxt  = S_FIN;
            end else begin
              // restart the scan at the first entry, once
              wrap_nxt = 1'b1;
              cur_nxt  = 13'd0;
            end
          end else begin
            state_nxt = S_RD0;
          end
        end else if (!ent_ok) begin
          res_st_nxt = ST_ERR;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        ram_addr  = base_a;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        ram_addr  = base1_a;
        b0_nxt    = ram_rdata;
        state_nxt = S_EV;
      end
      S_EV: begin
        unique case (mode_r)
          MODE_GET: begin
            res_eout_nxt = cls;
            state_nxt    = S_FIN;
          end
          MODE_SET: begin
            // splice the new value into the nibbles the entry owns
            if (cur_r[0]) begin
              nb0_nxt = (b0_r & NIB_LO) | ({v_r[3:0], 4'd0} & NIB_HI);
              nb1_nxt = v_r[11:4];
            end else begin
              nb0_nxt = v_r[7:0];
              nb1_nxt = (ram_rdata & NIB_HI) | ({4'd0, v_r[11:8]} & NIB_LO);
            end
            state_nxt = S_WR0;
          end
          default: begin
            if (raw == 12'd0) begin
              res_eout_nxt = cur_r[11:0];
              state_nxt    = S_FIN;
            end else begin
              cur_nxt   = cur_r + 13'd1;
              state_nxt = S_CHK;
            end
          end
        endcase
      end
      S_WR0: begin
        ram_we    = 1'b1;
        ram_addr  = base_a;
        ram_wdata = nb0_r;
        dirty_nxt = dirty_r | sector_bit(base_a);
        state_nxt = S_WR1;
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_addr  = base1_a;
        ram_wdata = nb1_r;
        dirty_nxt = dirty_r | sector_bit(base1_a);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_eout_nxt  = res_eout_r;
          out_bout_nxt  = res_bout_r;
          out_st_nxt    = res_st_r;
          out_dirty_nxt = 9'(dirty_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dirty_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dirty_r     <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    n_r         <= n_nxt;
    v_r         <= v_nxt;
    cur_r       <= cur_nxt;
    wrap_r      <= wrap_nxt;
    b0_r        <= b0_nxt;
    nb0_r       <= nb0_nxt;
    nb1_r       <= nb1_nxt;
    res_eout_r  <= res_eout_nxt;
    res_bout_r  <= res_bout_nxt;
    res_st_r    <= res_st_nxt;
    out_eout_r  <= out_eout_nxt;
    out_bout_r  <= out_bout_nxt;
    out_st_r    <= out_st_nxt;
    out_dirty_r <= out_dirty_nxt;
  end

endmodule
